// ----- src/dpa_pkg.sv -----
// types and constants for the dithered period aligner
// sequencer states, command and register codes, fixed field widths
// no dependencies
package dpa_pkg;

	// fixed field widths
	localparam int unsigned TICK_W   = 64;
	localparam int unsigned FIX_W    = 32;
	localparam int unsigned CFG_W    = 16;
	localparam int unsigned OUT_PW   = 16;
	localparam int unsigned DELTA_W  = 32;
	localparam int unsigned S_DATA_W = 224;
	localparam int unsigned M_DATA_W = 152;

	// register reset values
	localparam logic [CFG_W-1:0] MIN_PERIOD_RESET = 16'd100;
	localparam logic [CFG_W-1:0] NOMINAL_RESET    = 16'd40000;

	// command carried in tuser
	typedef enum logic [1:0] {
		CMD_BOUNDARY = 2'd0,
		CMD_ALIGN    = 2'd1,
		CMD_START    = 2'd2
	} cmd_t;

	// configuration register index
	typedef enum logic [0:0] {
		REG_MIN_PERIOD = 1'b0,
		REG_NOMINAL    = 1'b1
	} reg_idx_t;

	// run state of the timer
	typedef enum logic [1:0] {
		RUN_STOPPED = 2'd0,
		RUN_RUNNING = 2'd1,
		RUN_ALIGNED = 2'd2
	} run_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CNT,
		ST_TICK,
		ST_ALIGN,
		ST_ROLL,
		ST_RCNT,
		ST_DITHER,
		ST_CDELTA,
		ST_PDELTA,
		ST_SAT
	} state_t;

endpackage

// ----- src/dithered_period_aligner.sv -----
// dithered period aligner: period timer with fixed-point dithering and alignment
// depends on dpa_pkg
// Sequence: a boundary runs CNT, TICK, DITHER, SAT; with alignment CNT, TICK, ALIGN, ROLL
// (and RCNT per roll step, up to MAX_ROLL_STEPS), CDELTA, PDELTA, SAT; start/align run in IDLE.
// Throughput: one item at a time; the 64-bit shared adder serializes all wide arithmetic.
// The result waits in an output register, so the next item is taken while it is pending.
// Reset: arst_n clears the sequencer, run state and registers to their defaults.
module dithered_period_aligner #(
	parameter int unsigned FRAC_BITS      = 16,
	parameter int unsigned MAX_ROLL_STEPS = 64,
	parameter int unsigned PERIOD_BITS    = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_we,
	input  dpa_pkg::reg_idx_t             cfg_addr,
	input  logic [dpa_pkg::CFG_W-1:0]     cfg_wdata,
	// input items
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// target_cycle, target_ticks, target_base_period, base_offset
	input  logic [dpa_pkg::S_DATA_W-1:0]  s_tdata,
	// cmd
	input  logic [1:0]                    s_tuser,
	// result items
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// new_period, cycle_count, release_force, callback_fire, feedback_valid,
	// cyc_delta, period_delta, fault, zero pad
	output logic [dpa_pkg::M_DATA_W-1:0]  m_tdata
);
	import dpa_pkg::*;

	localparam int unsigned ACC_W  = FRAC_BITS;
	localparam int unsigned STEP_W = $clog2(MAX_ROLL_STEPS + 1);

	state_t state_q, state_d;

	// configuration
	logic [CFG_W-1:0] min_period_q;
	logic [CFG_W-1:0] nominal_q;

	// timer state
	run_t                   run_q;
	logic [TICK_W-1:0]      cnt_q;
	logic [TICK_W-1:0]      tick_q;
	logic [PERIOD_BITS-1:0] active_q;
	logic [PERIOD_BITS-1:0] shadow_q;
	logic [TICK_W-1:0]      last_q;
	logic [FIX_W-1:0]       bpf_q;
	logic [ACC_W-1:0]       acc_q;
	logic [TICK_W-1:0]      pend_cycle_q;
	logic [TICK_W-1:0]      pend_ticks_q;
	logic [FIX_W-1:0]       pend_period_q;
	logic                   pend_q;
	logic                   first_aligned_q;

	// working registers of one boundary
	logic [TICK_W-1:0]  p_q;
	logic [TICK_W-1:0]  old_c_q;
	logic [STEP_W-1:0]  steps_q;
	logic               rel_q;
	logic               fb_q;
	logic               fault_q;
	logic [DELTA_W-1:0] cdelta_q;
	logic [DELTA_W-1:0] pdelta_q;

	// output register
	logic                 out_valid_q;
	logic [M_DATA_W-1:0]  out_data_q;

	// shared adder
	logic [TICK_W-1:0] add_a, add_b, add_sum;
	logic              add_sub, add_cin;

	// dither fraction
	logic [ACC_W:0]    acc_sum;
	logic              acc_carry;
	logic [TICK_W-1:0] int_part;

	// saturation
	logic                   p_low, p_high;
	logic [PERIOD_BITS-1:0] p_sat;
	logic                   roll_lt;
	logic                   s_xfer, out_load;
	cmd_t                   cmd;

	assign cmd      = cmd_t'(s_tuser);
	assign s_tready = (state_q == ST_IDLE);
	assign s_xfer   = s_tvalid && s_tready;
	assign out_load = (state_q == ST_SAT) && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// fraction accumulation for one dither step
	assign acc_sum   = {1'b0, acc_q} + {1'b0, bpf_q[FRAC_BITS-1:0]};
	assign acc_carry = acc_sum[ACC_W];
	assign int_part  = TICK_W'(bpf_q >> FRAC_BITS);

	assign add_sum = add_a + (add_sub ? ~add_b : add_b) + TICK_W'(add_sub | add_cin);

	assign roll_lt = $signed(p_q) < $signed({{(TICK_W-CFG_W){1'b0}}, min_period_q});

	assign p_low  = p_q[TICK_W-1] || (p_q == '0);
	assign p_high = !p_q[TICK_W-1] && (|p_q[TICK_W-1:PERIOD_BITS]);
	assign p_sat  = p_low ? PERIOD_BITS'(1) : (p_high ? '1 : p_q[PERIOD_BITS-1:0]);

	// next state and adder operands
	always_comb begin
		state_d = state_q;
		add_a   = cnt_q;
		add_b   = TICK_W'(1);
		add_sub = 1'b0;
		add_cin = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_xfer && cmd == CMD_BOUNDARY && run_q != RUN_STOPPED)
					state_d = ST_CNT;
			end
			ST_CNT: begin
				state_d = ST_TICK;
			end
			ST_TICK: begin
				add_a   = tick_q;
				add_b   = TICK_W'(active_q);
				state_d = pend_q ? ST_ALIGN : ST_DITHER;
			end
			ST_ALIGN: begin
				add_a   = pend_ticks_q;
				add_b   = tick_q;
				add_sub = 1'b1;
				state_d = ST_ROLL;
			end
			ST_ROLL: begin
				add_a   = p_q;
				add_b   = int_part;
				add_cin = acc_carry;
				if (!roll_lt || steps_q == STEP_W'(MAX_ROLL_STEPS))
					state_d = ST_CDELTA;
				else
					state_d = ST_RCNT;
			end
			ST_RCNT: begin
				state_d = ST_ROLL;
			end
			ST_DITHER: begin
				add_a   = '0;
				add_b   = int_part;
				add_cin = acc_carry;
				state_d = ST_SAT;
			end
			ST_CDELTA: begin
				add_a   = cnt_q;
				add_b   = old_c_q;
				add_sub = 1'b1;
				state_d = ST_PDELTA;
			end
			ST_PDELTA: begin
				add_a   = p_q;
				add_b   = last_q;
				add_sub = 1'b1;
				state_d = ST_SAT;
			end
			ST_SAT: begin
				if (out_load)
					state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_period_q <= MIN_PERIOD_RESET;
			nominal_q    <= NOMINAL_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_MIN_PERIOD: min_period_q <= cfg_wdata;
				REG_NOMINAL:    nominal_q    <= cfg_wdata;
				default:        ;
			endcase
		end
	end

	// timer state and boundary datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q           <= RUN_STOPPED;
			cnt_q           <= '1;
			tick_q          <= '0;
			active_q        <= '0;
			shadow_q        <= PERIOD_BITS'(NOMINAL_RESET);
			last_q          <= TICK_W'(NOMINAL_RESET);
			bpf_q           <= FIX_W'(NOMINAL_RESET) << FRAC_BITS;
			acc_q           <= '0;
			pend_cycle_q    <= '0;
			pend_ticks_q    <= '0;
			pend_period_q   <= '0;
			pend_q          <= 1'b0;
			first_aligned_q <= 1'b0;
			p_q             <= '0;
			old_c_q         <= '0;
			steps_q         <= '0;
			rel_q           <= 1'b0;
			fb_q            <= 1'b0;
			fault_q         <= 1'b0;
			cdelta_q        <= '0;
			pdelta_q        <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					// alignment request latch and start
					if (s_xfer && cmd == CMD_ALIGN) begin
						pend_cycle_q  <= s_tdata[63:0];
						pend_ticks_q  <= s_tdata[127:64];
						pend_period_q <= s_tdata[159:128];
						pend_q        <= 1'b1;
					end
					if (s_xfer && cmd == CMD_START && run_q == RUN_STOPPED) begin
						tick_q   <= s_tdata[223:160];
						cnt_q    <= '0;
						run_q    <= RUN_RUNNING;
						last_q   <= TICK_W'(nominal_q);
						shadow_q <= PERIOD_BITS'(nominal_q);
						bpf_q    <= FIX_W'(nominal_q) << FRAC_BITS;
						acc_q    <= '0;
					end
				end
				ST_CNT: begin
					rel_q           <= first_aligned_q;
					first_aligned_q <= 1'b0;
					fb_q            <= 1'b0;
					fault_q         <= 1'b0;
					cdelta_q        <= '0;
					pdelta_q        <= '0;
					cnt_q           <= add_sum;
				end
				ST_TICK: begin
					tick_q   <= add_sum;
					active_q <= shadow_q;
				end
				ST_ALIGN: begin
					old_c_q <= cnt_q;
					cnt_q   <= pend_cycle_q;
					p_q     <= add_sum;
					bpf_q   <= pend_period_q;
					acc_q   <= '0;
					steps_q <= '0;
				end
				ST_ROLL: begin
					// one dithered step while below the minimum
					if (roll_lt) begin
						if (steps_q == STEP_W'(MAX_ROLL_STEPS)) begin
							fault_q <= 1'b1;
						end else begin
							p_q     <= add_sum;
							acc_q   <= acc_sum[ACC_W-1:0];
							steps_q <= steps_q + STEP_W'(1);
						end
					end
				end
				ST_RCNT: begin
					cnt_q <= add_sum;
				end
				ST_DITHER: begin
					p_q   <= add_sum;
					acc_q <= acc_sum[ACC_W-1:0];
				end
				ST_CDELTA: begin
					cdelta_q <= add_sum[DELTA_W-1:0];
				end
				ST_PDELTA: begin
					pdelta_q <= add_sum[DELTA_W-1:0];
					pend_q   <= 1'b0;
					fb_q     <= 1'b1;
					if (run_q == RUN_RUNNING) begin
						run_q           <= RUN_ALIGNED;
						first_aligned_q <= 1'b1;
					end
				end
				ST_SAT: begin
					if (out_load) begin
						last_q   <= p_q;
						shadow_q <= p_sat;
					end
				end
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
			out_data_q  <= {4'b0, fault_q | p_low | p_high, pdelta_q, cdelta_q, fb_q,
				run_q == RUN_ALIGNED, rel_q, cnt_q, OUT_PW'(p_sat)};
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule
